### hw/rtl/rrvc_pkg.sv
package rrvc_pkg;

  localparam int NUM_CH      = 8;
  localparam int CH_W        = $clog2(NUM_CH);
  localparam int PAY_W       = 32;
  localparam int CNT_W       = 4;
  localparam int OP_W        = 3;
  localparam int MASK_W      = NUM_CH;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_REQ       = 3'd0,
    OP_PICK      = 3'd1,
    OP_PICK_MASK = 3'd2,
    OP_PULL      = 3'd3,
    OP_CLEAR     = 3'd4,
    OP_STATUS    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_WIN  = 2'd1,
    ST_NOT_REQ = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic cap;   // capture the request from the input channel
    logic exec;  // commit the operation and load the result register
  } cmd_t;

endpackage

### hw/rtl/rrvc_ctrl.sv
module rrvc_ctrl
  import rrvc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic out_tready,
  output logic in_tready,
  output logic out_tvalid,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd.cap       = 1'b0;
    cmd.exec      = 1'b0;
    in_tready     = 1'b0;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait until the result register is free or drains this cycle
        if (!out_valid_r || out_tready) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

### hw/rtl/rrvc_dp.sv
module rrvc_dp
  import rrvc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  input  logic [OP_W-1:0]        in_op,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  logic                   cfg_we,
  input  logic [CNT_W-1:0]       cfg_wdata,
  output logic [OUT_TDATA_W-1:0] out_data,
  output logic [OUT_TUSER_W-1:0] out_user
);

  typedef struct packed {
    logic            found;
    logic [CH_W-1:0] idx;
  } scan_t;

  // Rotating priority encoder: first eligible channel after last
  function automatic scan_t rr_scan(input logic [NUM_CH-1:0] elig,
                                    input logic [CH_W-1:0]   last);
    scan_t           res;
    logic [CH_W-1:0] i;
    res.found = 1'b0;
    res.idx   = last;
    for (int k = NUM_CH; k >= 1; k--) begin
      i = last + CH_W'(k);
      if (elig[i]) begin
        res.found = 1'b1;
        res.idx   = i;
      end
    end
    return res;
  endfunction

  // Captured request
  logic [OP_W-1:0]   op_r;
  logic [CH_W-1:0]   ch_r;
  logic [PAY_W-1:0]  pay_r;
  logic [MASK_W-1:0] mask_r;

  // Arbiter state
  logic [CNT_W-1:0]  active_r;
  logic [NUM_CH-1:0] flags_r, flags_nxt;
  logic [PAY_W-1:0]  pay_mem_r [NUM_CH];
  logic [CH_W-1:0]   last_r, last_nxt;
  logic              picked_r, picked_nxt;

  // Result register
  logic [OUT_TDATA_W-1:0] odata_r, odata_nxt;
  logic [OUT_TUSER_W-1:0] ouser_r, ouser_nxt;

  logic [CNT_W-1:0]  n_ch;
  logic              in_range;
  logic              pay_we;
  scan_t             sc;
  logic [CH_W-1:0]   grant;
  logic              win_valid;
  logic [PAY_W-1:0]  pay_out;
  status_t           status;
  logic              ch_req;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r   <= in_op;
      ch_r   <= in_data[CH_W-1:0];
      pay_r  <= in_data[CH_W +: PAY_W];
      mask_r <= in_data[CH_W+PAY_W +: MASK_W];
    end
    if (cmd.exec) begin
      odata_r <= odata_nxt;
      ouser_r <= ouser_nxt;
      if (pay_we) pay_mem_r[ch_r] <= pay_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= CNT_W'(NUM_CH);
      flags_r  <= '0;
      last_r   <= '0;
      picked_r <= 1'b0;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
      flags_r  <= '0;
    end else if (cmd.exec) begin
      flags_r  <= flags_nxt;
      last_r   <= last_nxt;
      picked_r <= picked_nxt;
    end
  end

  always_comb begin
    if (active_r == '0) n_ch = CNT_W'(1);
    else if (active_r > CNT_W'(NUM_CH)) n_ch = CNT_W'(NUM_CH);
    else n_ch = active_r;
  end

  assign in_range = {1'b0, ch_r} < n_ch;
  assign sc = rr_scan(flags_r & ((op_r == OP_PICK_MASK) ? mask_r : '1), last_r);

  always_comb begin
    flags_nxt  = flags_r;
    last_nxt   = last_r;
    picked_nxt = picked_r;
    pay_we     = 1'b0;
    win_valid  = 1'b0;
    pay_out    = '0;
    status     = ST_OK;
    grant      = picked_r ? last_r : sc.idx;
    unique case (op_r)
      OP_REQ: begin
        if (in_range) begin
          flags_nxt[ch_r] = 1'b1;
          pay_we          = 1'b1;
        end else begin
          status = ST_RANGE;
        end
      end
      OP_PICK, OP_PICK_MASK: begin
        if (picked_r) begin
          win_valid = 1'b1;
        end else begin
          picked_nxt = 1'b1;
          if (sc.found) begin
            last_nxt  = sc.idx;
            win_valid = 1'b1;
          end else begin
            status = ST_NO_WIN;
          end
        end
      end
      OP_PULL: begin
        picked_nxt = 1'b0;
        if (!picked_r && !sc.found) begin
          status = ST_NO_WIN;
        end else begin
          last_nxt = grant;
          if (!flags_r[grant]) begin
            status = ST_NOT_REQ;
          end else begin
            flags_nxt[grant] = 1'b0;
            pay_out          = pay_mem_r[grant];
            win_valid        = 1'b1;
          end
        end
      end
      OP_CLEAR: flags_nxt[last_r] = 1'b0;
      default: begin
        if (!in_range) status = ST_RANGE;
      end
    endcase
  end

  assign ch_req = in_range & flags_nxt[ch_r];

  always_comb begin
    odata_nxt = {2'b00,
                 ~|(flags_nxt & mask_r),
                 ~|flags_nxt,
                 ch_req,
                 pay_out,
                 last_nxt};
    ouser_nxt = {status, win_valid};
  end

  assign out_data = odata_r;
  assign out_user = ouser_r;

endmodule

### hw/rtl/round_robin_vc_arbiter_core.sv
// Channel | Dir | Handshake          | Contents
// in      | in  | in_tvalid/tready   | tuser op, tdata channel/payload_in/ready_mask
// out     | out | out_tvalid/tready  | tuser winner_valid/status, tdata winner/payload/flags
// cfg     | in  | cfg_we             | cfg_wdata active_channels, no wait
//
// Each request passes through S_IDLE, which captures it, and S_EXEC, which runs
// the channel scan (a combinational rotating priority encoder) and commits the state.
// The result register frees the input side: a new request is taken while a
// result still waits; the commit stalls only while it waits and out_tready is low.
// Reset (rst_n low, synchronous) clears all request flags, the last grant and
// the picked flag, and sets active_channels to eight. No clearing pass.
module round_robin_vc_arbiter_core
  import rrvc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata from bit 0: channel[2:0], payload_in[34:3], ready_mask[42:35], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: op[2:0]
  input  logic [OP_W-1:0]        in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // out_tdata from bit 0: winner[2:0], payload_out[34:3], channel_requested[35],
  //   all_empty[36], ready_empty[37], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser from bit 0: winner_valid[0], status[2:1]
  output logic [OUT_TUSER_W-1:0] out_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic [CNT_W-1:0]       cfg_wdata
);

  cmd_t cmd;

  // Sequence capture and commit; hold the result until the sink takes it
  rrvc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .out_tready (out_tready),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  // Request flags, payload handles, grant pointer and result register
  rrvc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_op     (in_tuser),
    .in_data   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_tdata),
    .out_user  (out_tuser)
  );

  // A commit always leaves a result in the output register
  a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_tvalid)
    else $error("commit did not produce a result");

  // Capture moves the controller out of idle into the commit state
  a_cap_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap |=> !in_tready)
    else $error("input accepted twice without a commit");

  // A winner is reported only with an ok status
  a_win_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[2:1] == ST_OK)
    else $error("winner reported with error status");

  // Payload comes out only with a winner
  a_pay_win: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[34:3] == '0)
    else $error("payload without winner");

endmodule
